[rtl/wqs_pkg.sv]
// Shared types and constants of the two-queue weighted random scheduler.
package wqs_pkg;

  // Field widths fixed by the command format.
  localparam int unsigned TimeW    = 16;
  localparam int unsigned PctW     = 7;
  localparam int unsigned DrawW    = 7;
  localparam int unsigned ProdW    = TimeW + PctW;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  // Register reset values.
  localparam logic [TimeW-1:0] MaxTimeRst     = 16'd1000;
  localparam logic [PctW-1:0]  LongPctRst     = 7'd30;
  localparam logic [PctW-1:0]  FirstChanceRst = 7'd70;

  typedef enum logic {
    CMD_SCHEDULE = 1'b0,
    CMD_ADMIT    = 1'b1
  } cmd_e;

  typedef enum logic {
    QUEUE_FIRST  = 1'b0,
    QUEUE_SECOND = 1'b1
  } queue_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MAX_TIME     = 2'd0,
    CFG_LONG_PCT     = 2'd1,
    CFG_FIRST_CHANCE = 2'd2
  } cfg_idx_e;

  // Configuration as seen by the decision logic.
  typedef struct packed {
    logic [ProdW-1:0] limit_x100;
    logic [PctW-1:0]  first_chance;
  } cfg_t;

  // Per-queue control from the decision logic.
  typedef struct packed {
    logic push;
    logic pop;
  } fifo_ctrl_t;

  // Per-queue status towards the decision logic.
  typedef struct packed {
    logic full;
    logic avail;
  } fifo_stat_t;

endpackage

[rtl/wqs_cfg.sv]
// Configuration registers and the registered long-job limit product.
module wqs_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [wqs_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [wqs_pkg::CfgDataW-1:0]  cfg_wdata_i,
  output wqs_pkg::cfg_t                 cfg_o
);
  import wqs_pkg::*;

  logic [TimeW-1:0] max_time_q;
  logic [PctW-1:0]  long_pct_q;
  logic [PctW-1:0]  first_chance_q;
  logic [ProdW-1:0] prod_q;

  // Register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_time_q     <= MaxTimeRst;
      long_pct_q     <= LongPctRst;
      first_chance_q <= FirstChanceRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_MAX_TIME:     max_time_q     <= cfg_wdata_i[TimeW-1:0];
        CFG_LONG_PCT:     long_pct_q     <= cfg_wdata_i[PctW-1:0];
        CFG_FIRST_CHANCE: first_chance_q <= cfg_wdata_i[PctW-1:0];
        default: ;
      endcase
    end
  end

  // The limit is compared against total_time scaled by one hundred, which
  // gives the same answer as comparing against the truncated quotient.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_q <= ProdW'(MaxTimeRst * LongPctRst);
    end else begin
      prod_q <= ProdW'(max_time_q) * ProdW'(long_pct_q);
    end
  end

  assign cfg_o.limit_x100   = prod_q;
  assign cfg_o.first_chance = first_chance_q;

endmodule

[rtl/wqs_fifo.sv]
// One circular queue of process IDs with a same-cycle push-to-pop bypass.
module wqs_fifo #(
  parameter int unsigned Depth = 16,
  parameter int unsigned IdW   = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  wqs_pkg::fifo_ctrl_t  ctrl_i,
  input  logic [IdW-1:0]       push_id_i,
  output wqs_pkg::fifo_stat_t  stat_o,
  output logic [IdW-1:0]       pop_id_o
);
  import wqs_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam int unsigned SumW = CntW + 1;

  logic [IdW-1:0]  store_q [Depth];
  logic [PtrW-1:0] head_q, head_d;
  logic [CntW-1:0] count_q, count_d;
  logic [SumW-1:0] tail_sum;
  logic [PtrW-1:0] tail;
  logic            full;
  logic            push_ok;
  logic            pop_ok;

  assign full    = (count_q == CntW'(Depth));
  assign push_ok = ctrl_i.push & ~full;
  assign pop_ok  = ctrl_i.pop & stat_o.avail;

  // Write position is head plus count, wrapped at the depth.
  always_comb begin
    tail_sum = SumW'(head_q) + SumW'(count_q);
    if (tail_sum >= SumW'(Depth)) begin
      tail_sum = tail_sum - SumW'(Depth);
    end
    tail = tail_sum[PtrW-1:0];
  end

  // An empty queue that takes a push this cycle can hand the same ID out.
  assign stat_o.full  = full;
  assign stat_o.avail = (count_q != '0) | push_ok;
  assign pop_id_o     = (count_q == '0) ? push_id_i : store_q[head_q];

  // Pointer and count update.
  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    if (pop_ok) begin
      head_d = (head_q == PtrW'(Depth - 1)) ? '0 : head_q + PtrW'(1);
    end
    if (push_ok && !pop_ok) begin
      count_d = count_q + CntW'(1);
    end else if (!push_ok && pop_ok) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      store_q[tail] <= push_id_i;
    end
  end

endmodule

[rtl/two_queue_weighted_random_scheduler.sv]
// Top level of the two-queue weighted random scheduler.
//
//   Channel   | Handshake               | Payload
//   ----------+-------------------------+------------------------------------------
//   command   | start_i high, busy_o low| command, has_current, current_id, ...
//   result    | done_o strobe, 1 cycle  | selected_valid/id/queue, finished, overflow
//   config    | cfg_we_i                | cfg_index_i, cfg_wdata_i
//
// An accepted command is registered, decided in the following cycle and its
// result is shown on the strobe in the cycle after that.
// busy_o stays low, so a command can be taken at every clock edge; queue state
// is updated when each decision is registered, so the next command sees it.
// Reset empties both queues and loads the register defaults; the receiver
// cannot stall the result transfer.
module two_queue_weighted_random_scheduler #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned ID_WIDTH    = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic                          command_i,
  input  logic                          has_current_i,
  input  logic [ID_WIDTH-1:0]           current_id_i,
  input  logic signed [wqs_pkg::TimeW-1:0] remaining_time_i,
  input  logic [wqs_pkg::TimeW-1:0]     total_time_i,
  input  logic [wqs_pkg::DrawW-1:0]     draw_i,
  input  logic                          admit_queue_i,
  input  logic                          cfg_we_i,
  input  logic [wqs_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [wqs_pkg::CfgDataW-1:0]  cfg_wdata_i,
  output logic                          done_o,
  output logic                          selected_valid_o,
  output logic [ID_WIDTH-1:0]           selected_id_o,
  output logic                          selected_queue_o,
  output logic                          current_finished_o,
  output logic                          overflow_o
);
  import wqs_pkg::*;

  cfg_t       cfg;
  fifo_ctrl_t ctrl  [2];
  fifo_stat_t stat  [2];
  logic [ID_WIDTH-1:0] pop_id [2];

  // Command register.
  logic                    in_valid_q;
  cmd_e                    cmd_q;
  logic                    has_cur_q;
  logic [ID_WIDTH-1:0]     id_q;
  logic signed [TimeW-1:0] rem_q;
  logic [TimeW-1:0]        total_q;
  logic [DrawW-1:0]        draw_q;
  queue_e                  admit_q_q;

  // Decision signals.
  logic          admit;
  logic          cur_done;
  logic          is_long;
  logic [ProdW-1:0] total_x100;
  logic          push_any;
  queue_e        push_q;
  queue_e        pref_q;
  queue_e        other_q;
  logic          sel_valid;
  queue_e        sel_q;
  logic          fin;
  logic          ovf;

  // Result register.
  logic                done_q;
  logic                sel_valid_q;
  logic [ID_WIDTH-1:0] sel_id_q;
  logic                sel_q_q;
  logic                fin_q;
  logic                ovf_q;

  assign busy_o = 1'b0;

  wqs_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Capture of an accepted command.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= start_i & ~busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      cmd_q     <= cmd_e'(command_i);
      has_cur_q <= has_current_i;
      id_q      <= current_id_i;
      rem_q     <= remaining_time_i;
      total_q   <= total_time_i;
      draw_q    <= draw_i;
      admit_q_q <= queue_e'(admit_queue_i);
    end
  end

  // Insert: an admitted ID, or a returning process that still has time left.
  always_comb begin
    admit      = (cmd_q == CMD_ADMIT);
    cur_done   = rem_q[TimeW-1] | (rem_q == '0);
    total_x100 = (ProdW'(total_q) << 6) + (ProdW'(total_q) << 5) + (ProdW'(total_q) << 2);
    is_long    = (total_x100 > cfg.limit_x100);
    push_any   = in_valid_q & (admit | (has_cur_q & ~cur_done));
    fin        = in_valid_q & ~admit & has_cur_q & cur_done;
    if (admit) begin
      push_q = admit_q_q;
    end else begin
      push_q = is_long ? QUEUE_FIRST : QUEUE_SECOND;
    end
    ovf = push_any & stat[push_q].full;
  end

  // Selection after the insert: preferred queue first, then the other one.
  always_comb begin
    pref_q    = (draw_q < cfg.first_chance) ? QUEUE_FIRST : QUEUE_SECOND;
    other_q   = (pref_q == QUEUE_FIRST) ? QUEUE_SECOND : QUEUE_FIRST;
    sel_valid = 1'b0;
    sel_q     = QUEUE_FIRST;
    if (in_valid_q && !admit) begin
      if (stat[pref_q].avail) begin
        sel_valid = 1'b1;
        sel_q     = pref_q;
      end else if (stat[other_q].avail) begin
        sel_valid = 1'b1;
        sel_q     = other_q;
      end
    end
  end

  always_comb begin
    ctrl[0].push = push_any & (push_q == QUEUE_FIRST);
    ctrl[1].push = push_any & (push_q == QUEUE_SECOND);
    ctrl[0].pop  = sel_valid & (sel_q == QUEUE_FIRST);
    ctrl[1].pop  = sel_valid & (sel_q == QUEUE_SECOND);
  end

  for (genvar g = 0; g < 2; g++) begin : g_queue
    wqs_fifo #(
      .Depth (QUEUE_DEPTH),
      .IdW   (ID_WIDTH)
    ) u_fifo (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl[g]),
      .push_id_i (id_q),
      .stat_o    (stat[g]),
      .pop_id_o  (pop_id[g])
    );
  end

  // Result transfer register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_q) begin
      sel_valid_q <= sel_valid;
      sel_id_q    <= sel_valid ? pop_id[sel_q] : '0;
      sel_q_q     <= sel_valid ? sel_q : QUEUE_FIRST;
      fin_q       <= fin;
      ovf_q       <= ovf;
    end
  end

  assign done_o             = done_q;
  assign selected_valid_o   = sel_valid_q;
  assign selected_id_o      = sel_id_q;
  assign selected_queue_o   = sel_q_q;
  assign current_finished_o = fin_q;
  assign overflow_o         = ovf_q;

`ifndef NO_ASSERTIONS
  // Every accepted command yields exactly one result strobe.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##2 done_o)
    else $error("accepted command produced no result strobe");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |=> !done_o)
    else $error("result strobe without a command in flight");

  // A pop only ever targets a queue with an entry available, and only one queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!ctrl[0].pop || stat[0].avail) && (!ctrl[1].pop || stat[1].avail))
    else $error("pop from an empty queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctrl[0].pop && ctrl[1].pop))
    else $error("both queues popped for one command");
`endif

endmodule
